### design/dmf_pkg.sv
package dmf_pkg;

  localparam int DEF_MAX_ITEMS    = 8;
  localparam int DEF_MAX_ITEM_LEN = 16;

  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
  localparam logic [1:0] ERR_MSG_LEN  = 2'd2;
  localparam logic [1:0] ERR_ITEM_LEN = 2'd3;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_STOP  = 2'd1;
  localparam logic [1:0] CFG_SEP   = 2'd2;

  localparam logic [7:0] START_RST = 8'd91;
  localparam logic [7:0] STOP_RST  = 8'd93;
  localparam logic [7:0] SEP_RST   = 8'd44;

  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_SP  = 8'd32;
  localparam logic [7:0] CHAR_NUL = 8'd0;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] stop_char;
    logic [7:0] sep_char;
  } dmf_cfg_t;

  typedef struct packed {
    logic char_we;
    logic len_we;
    logic rd_en;
  } dmf_mem_cmd_t;

  typedef struct packed {
    logic       message_ready;
    logic       receiving;
    logic [3:0] item_count;
    logic [1:0] error_code;
  } dmf_status_t;

endpackage

### design/dmf_store.sv
module dmf_store #(
  parameter int MAX_ITEMS    = dmf_pkg::DEF_MAX_ITEMS,
  parameter int MAX_ITEM_LEN = dmf_pkg::DEF_MAX_ITEM_LEN,
  localparam int AW = $clog2(MAX_ITEMS * MAX_ITEM_LEN),
  localparam int LW = $clog2(MAX_ITEMS),
  localparam int PW = $clog2(MAX_ITEM_LEN + 1)
) (
  input  logic                 clk,
  input  dmf_pkg::dmf_mem_cmd_t cmd,
  input  logic [AW-1:0]        char_waddr,
  input  logic [7:0]           char_wdata,
  input  logic [LW-1:0]        len_waddr,
  input  logic [PW-1:0]        len_wdata,
  input  logic [AW-1:0]        char_raddr,
  input  logic [LW-1:0]        len_raddr,
  output logic [7:0]           char_q,
  output logic [PW-1:0]        len_q
);

  logic [7:0]    char_mem [MAX_ITEMS * MAX_ITEM_LEN];
  logic [PW-1:0] len_mem  [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (cmd.char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (cmd.rd_en) begin
      char_q <= char_mem[char_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (cmd.rd_en) begin
      len_q <= len_mem[len_raddr];
    end
  end

endmodule

### design/dmf_ctrl.sv
module dmf_ctrl #(
  parameter int MAX_ITEMS    = dmf_pkg::DEF_MAX_ITEMS,
  parameter int MAX_ITEM_LEN = dmf_pkg::DEF_MAX_ITEM_LEN,
  localparam int AW = $clog2(MAX_ITEMS * MAX_ITEM_LEN),
  localparam int LW = $clog2(MAX_ITEMS),
  localparam int PW = $clog2(MAX_ITEM_LEN + 1),
  localparam int IW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  dmf_pkg::dmf_cfg_t     cfg,
  input  logic [1:0]            mode,
  input  logic [7:0]            rx_byte,
  input  logic [2:0]            item_index,
  input  logic [3:0]            char_index,
  output dmf_pkg::dmf_mem_cmd_t cmd,
  output logic [AW-1:0]         char_waddr,
  output logic [LW-1:0]         len_waddr,
  output logic [PW-1:0]         len_wdata,
  output logic [AW-1:0]         char_raddr,
  output logic [LW-1:0]         len_raddr,
  output logic                  rd_ok_r,
  output logic [3:0]            pos_r,
  output dmf_pkg::dmf_status_t  status_r
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_MSG  = 2'd2;
  localparam int CW = (IW > 3) ? IW : 3;

  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [IW-1:0] items_r, items_nxt;
  logic [PW-1:0] cpos_r, cpos_nxt;
  logic          char_we, len_we, rd_ok;
  logic          blank;

  assign blank = (rx_byte == dmf_pkg::CHAR_NL) || (rx_byte == dmf_pkg::CHAR_SP);

  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    items_nxt = items_r;
    cpos_nxt  = cpos_r;
    char_we   = 1'b0;
    len_we    = 1'b0;
    rd_ok     = 1'b0;
    case (mode)
      dmf_pkg::MODE_RX: begin
        if (rx_byte != dmf_pkg::CHAR_NUL) begin
          case (phase_r)
            PH_IDLE: begin
              if (rx_byte == cfg.start_char) begin
                items_nxt = '0;
                cpos_nxt  = '0;
                phase_nxt = PH_RECV;
                err_nxt   = dmf_pkg::ERR_NONE;
              end else if (!blank) begin
                items_nxt = '0;
                cpos_nxt  = '0;
                err_nxt   = dmf_pkg::ERR_ILLEGAL;
              end
            end
            PH_RECV: begin
              if (rx_byte == cfg.start_char) begin
                items_nxt = '0;
                cpos_nxt  = '0;
                phase_nxt = PH_IDLE;
                err_nxt   = dmf_pkg::ERR_ILLEGAL;
              end else if (rx_byte == cfg.stop_char) begin
                if (cpos_r != '0) begin
                  len_we    = 1'b1;
                  items_nxt = items_r + IW'(1);
                  cpos_nxt  = '0;
                end
                phase_nxt = PH_MSG;
              end else if (rx_byte == cfg.sep_char) begin
                if (cpos_r == '0) begin
                  items_nxt = '0;
                  phase_nxt = PH_IDLE;
                  err_nxt   = dmf_pkg::ERR_ITEM_LEN;
                end else if (items_r >= IW'(MAX_ITEMS - 1)) begin
                  items_nxt = '0;
                  cpos_nxt  = '0;
                  phase_nxt = PH_IDLE;
                  err_nxt   = dmf_pkg::ERR_MSG_LEN;
                end else begin
                  len_we    = 1'b1;
                  items_nxt = items_r + IW'(1);
                  cpos_nxt  = '0;
                end
              end else if (cpos_r >= PW'(MAX_ITEM_LEN)) begin
                items_nxt = '0;
                cpos_nxt  = '0;
                phase_nxt = PH_IDLE;
                err_nxt   = dmf_pkg::ERR_ITEM_LEN;
              end else if (!blank) begin
                char_we  = 1'b1;
                cpos_nxt = cpos_r + PW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      dmf_pkg::MODE_READ: begin
        rd_ok = (phase_r == PH_MSG) && (CW'(item_index) < CW'(items_r));
      end
      dmf_pkg::MODE_CLEAR: begin
        items_nxt = '0;
        cpos_nxt  = '0;
        phase_nxt = PH_IDLE;
        err_nxt   = dmf_pkg::ERR_NONE;
      end
      default: begin
      end
    endcase
  end

  assign cmd.char_we = accept && char_we;
  assign cmd.len_we  = accept && len_we;
  assign cmd.rd_en   = accept;
  assign char_waddr  = AW'(int'(items_r) * MAX_ITEM_LEN + int'(cpos_r));
  assign len_waddr   = LW'(items_r);
  assign len_wdata   = cpos_r;
  assign char_raddr  = AW'(int'(item_index) * MAX_ITEM_LEN + int'(char_index));
  assign len_raddr   = LW'(item_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      err_r   <= dmf_pkg::ERR_NONE;
      items_r <= '0;
      cpos_r  <= '0;
      rd_ok_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      items_r <= items_nxt;
      cpos_r  <= cpos_nxt;
      rd_ok_r <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r                  <= char_index;
      status_r.message_ready <= (phase_nxt == PH_MSG);
      status_r.receiving     <= (phase_nxt == PH_RECV);
      status_r.item_count    <= (phase_nxt == PH_MSG) ? 4'(items_nxt) : 4'd0;
      status_r.error_code    <= err_nxt;
    end
  end

endmodule

### design/delimited_message_framer.sv
// channel  direction  fields, lowest bit first
// in_      slave      tuser: mode[1:0]; tdata: rx_byte[7:0] item_index[10:8] char_index[14:11]
// out_     master     tdata: read_char[7:0] message_ready[8] receiving[9]
//                     item_count[13:10] error_code[15:14]
// cfg_     write      cfg_index[1:0] (0 start, 1 stop, 2 separator), cfg_data[7:0]
//
// one item per cycle unless stalled; each item is one access to the character and length stores
// a result appears the cycle after its item is taken, from the store read register
// in_tready is low only while a result waits and out_tready is low
// rst_n returns to idle with no items; store contents are left as they are
module delimited_message_framer #(
  parameter int MAX_ITEMS    = dmf_pkg::DEF_MAX_ITEMS,
  parameter int MAX_ITEM_LEN = dmf_pkg::DEF_MAX_ITEM_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // rx_byte, item_index, char_index, zero fill
  input  logic [1:0]  in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // read_char, message_ready, receiving, item_count, error_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = $clog2(MAX_ITEMS * MAX_ITEM_LEN);
  localparam int LW = $clog2(MAX_ITEMS);
  localparam int PW = $clog2(MAX_ITEM_LEN + 1);
  localparam int QW = (PW > 4) ? PW : 4;

  dmf_pkg::dmf_cfg_t     cfg_r;
  dmf_pkg::dmf_mem_cmd_t cmd;
  dmf_pkg::dmf_status_t  status_r;
  logic                  out_valid_r;
  logic                  accept;
  logic [AW-1:0]         char_waddr, char_raddr;
  logic [LW-1:0]         len_waddr, len_raddr;
  logic [PW-1:0]         len_wdata, len_q;
  logic [7:0]            char_q;
  logic                  rd_ok_r;
  logic [3:0]            pos_r;
  logic [7:0]            read_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_char <= dmf_pkg::START_RST;
      cfg_r.stop_char  <= dmf_pkg::STOP_RST;
      cfg_r.sep_char   <= dmf_pkg::SEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dmf_pkg::CFG_START: cfg_r.start_char <= cfg_data;
        dmf_pkg::CFG_STOP:  cfg_r.stop_char  <= cfg_data;
        dmf_pkg::CFG_SEP:   cfg_r.sep_char   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  dmf_ctrl #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_ITEM_LEN (MAX_ITEM_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cfg        (cfg_r),
    .mode       (in_tuser),
    .rx_byte    (in_tdata[7:0]),
    .item_index (in_tdata[10:8]),
    .char_index (in_tdata[14:11]),
    .cmd        (cmd),
    .char_waddr (char_waddr),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .char_raddr (char_raddr),
    .len_raddr  (len_raddr),
    .rd_ok_r    (rd_ok_r),
    .pos_r      (pos_r),
    .status_r   (status_r)
  );

  dmf_store #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_ITEM_LEN (MAX_ITEM_LEN)
  ) u_store (
    .clk        (clk),
    .cmd        (cmd),
    .char_waddr (char_waddr),
    .char_wdata (in_tdata[7:0]),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .char_raddr (char_raddr),
    .len_raddr  (len_raddr),
    .char_q     (char_q),
    .len_q      (len_q)
  );

  // position must lie inside the stored item length
  assign read_char = (rd_ok_r && (QW'(pos_r) < QW'(len_q))) ? char_q : 8'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {status_r.error_code, status_r.item_count,
                       status_r.receiving, status_r.message_ready, read_char};

endmodule
